>>> src/mean_filter_3x3_5x5_core_assert.svh
// Assertion macros for the mean filter core checkers.
// Needs clk and rst_n in the scope of use.
`ifndef MEAN_FILTER_3X3_5X5_CORE_ASSERT_SVH
`define MEAN_FILTER_3X3_5X5_CORE_ASSERT_SVH

// Same-cycle implication.
`define MF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/mf_pkg.sv
// Shared types, constants and helper functions for the mean filter core.
// No dependencies.
package mf_pkg;

    localparam int PIX_W         = 8;
    localparam int IW_W          = 11;
    localparam int IH_W          = 13;
    localparam int OROW_W        = 12;
    localparam int CNT_W         = 13;
    localparam int CFG_W         = 13;
    localparam int CFG_IDX_W     = 2;
    localparam int WIN           = 5;
    localparam int LINE_COUNT    = 4;
    localparam int LINE_W        = $clog2(LINE_COUNT);
    localparam int DEF_MAX_WIDTH = 1024;
    localparam int MAX_HEIGHT    = 4096;
    localparam int Q_DEPTH       = 4;
    localparam int Q_LVL_W       = $clog2(Q_DEPTH + 1);
    localparam int TAP_W         = 10;
    localparam int RSUM_W        = 12;
    localparam int SUM_W         = 14;
    localparam int RECIP_W       = 15;
    localparam int PROD_W        = SUM_W + RECIP_W;
    localparam int DIV_SHIFT     = 18;

    localparam logic [RECIP_W-1:0] RECIP_9  = 15'd29128;
    localparam logic [RECIP_W-1:0] RECIP_35 = 15'd7490;

    localparam logic [CFG_IDX_W-1:0] REG_KERNEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    localparam logic [IW_W-1:0] RST_WIDTH  = 11'd640;
    localparam logic [IH_W-1:0] RST_HEIGHT = 13'd480;

    typedef logic [WIN-1:0][2:0] sel_vec_t;
    typedef logic [WIN-1:0][WIN-1:0][PIX_W-1:0] win_t;

    typedef struct packed {
        logic [WIN-1:0][PIX_W-1:0] px;
        logic                      emit;
        logic                      last;
        logic                      ksel;
        sel_vec_t                  age_sel;
        sel_vec_t                  row_sel;
    } col_entry_t;

    function automatic logic [1:0] tap_weight(input logic ksel, input int i, input int j);
        int di;
        int dj;
        int m;
        di = (i > 2) ? i - 2 : 2 - i;
        dj = (j > 2) ? j - 2 : 2 - j;
        m  = (di > dj) ? di : dj;
        if (ksel)
            return 2'(3 - m);
        else
            return (m <= 1) ? 2'd1 : 2'd0;
    endfunction

endpackage

>>> src/mf_ram.sv
// Generic single-write, single-read RAM with registered read (read-first).
// No dependencies.
module mf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/mf_front.sv
// Front end: configuration registers, position counters, line stores and
// column assembly. Depends on mf_pkg and mf_ram.
module mf_front
    import mf_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [PIX_W-1:0]     s_pixel,
    input  logic                 s_drain,
    input  logic [Q_LVL_W-1:0]   q_level,
    output logic                 push_v,
    output col_entry_t           push_data
);

    localparam int AW = $clog2(MAX_WIDTH);

    logic                ksel_reg;
    logic [IW_W-1:0]     width_reg;
    logic [IH_W-1:0]     height_reg;
    logic [IW_W-1:0]     in_col_reg,  in_col_next;
    logic [IH_W-1:0]     in_row_reg,  in_row_next;
    logic [CNT_W-1:0]    n_cnt_reg,   n_cnt_next;
    logic [IW_W-1:0]     out_col_reg, out_col_next;
    logic [OROW_W-1:0]   out_row_reg, out_row_next;

    logic                f1_v_reg;
    logic [LINE_W-1:0]   f1_row_lo_reg;
    logic [PIX_W-1:0]    f1_pix_reg;
    logic                f1_emit_reg;
    logic                f1_last_reg;
    logic                f1_ksel_reg;
    sel_vec_t            f1_age_reg;
    sel_vec_t            f1_rsel_reg;

    logic [IW_W-1:0]     w_eff;
    logic [IH_W-1:0]     h_eff;
    logic [CNT_W-1:0]    lag;
    logic                accept, in_frame, real_px, push, emit, last;
    logic [IW_W-1:0]     in_col_inc;
    logic [IH_W-1:0]     out_row_ext;
    logic signed [3:0]   p;
    sel_vec_t            age_sel, row_sel;
    logic [LINE_COUNT-1:0][PIX_W-1:0] ram_rd;

    function automatic logic signed [3:0] refl_off(input int k, input logic is0,
                                                   input logic is1, input logic isl,
                                                   input logic isl2);
        logic signed [3:0] o;
        case (k)
            0:       o = is0 ? 4'sd1 : (is1 ? -4'sd1 : -4'sd2);
            1:       o = is0 ? 4'sd0 : -4'sd1;
            3:       o = isl ? 4'sd0 : 4'sd1;
            4:       o = isl ? -4'sd1 : (isl2 ? 4'sd1 : 4'sd2);
            default: o = 4'sd0;
        endcase
        return o;
    endfunction

    always_comb
    begin
        if (width_reg < 11'd2)
            w_eff = 11'd2;
        else if (32'(width_reg) > MAX_WIDTH)
            w_eff = IW_W'(MAX_WIDTH);
        else
            w_eff = width_reg;
        if (height_reg < 13'd2)
            h_eff = 13'd2;
        else if (32'(height_reg) > MAX_HEIGHT)
            h_eff = IH_W'(MAX_HEIGHT);
        else
            h_eff = height_reg;
    end

    assign lag         = ksel_reg ? ((CNT_W'(w_eff) << 1) + 13'd2) : (CNT_W'(w_eff) + 13'd1);
    assign s_tready    = (32'(q_level) + 32'(f1_v_reg)) < Q_DEPTH;
    assign accept      = s_tvalid && s_tready;
    assign in_frame    = in_row_reg < h_eff;
    assign real_px     = in_frame && !s_drain;
    assign push        = !in_frame || !s_drain;
    assign emit        = push && (n_cnt_reg >= lag);
    assign out_row_ext = IH_W'(out_row_reg);
    assign last        = emit && (out_row_ext == h_eff - 13'd1) && (out_col_reg == w_eff - 11'd1);
    assign in_col_inc  = in_col_reg + 11'd1;
    assign p           = ksel_reg ? 4'sd2 : 4'sd1;

    always_comb
    begin
        logic signed [3:0] oc;
        logic signed [3:0] orow;
        logic signed [3:0] a;
        logic signed [3:0] b;
        for (int k = 0; k < WIN; k++)
        begin
            oc = refl_off(k, out_col_reg == 11'd0, out_col_reg == 11'd1,
                          out_col_reg == w_eff - 11'd1, out_col_reg == w_eff - 11'd2);
            orow = refl_off(k, out_row_ext == 13'd0, out_row_ext == 13'd1,
                            out_row_ext == h_eff - 13'd1, out_row_ext == h_eff - 13'd2);
            a = p - oc;
            b = orow + 4'sd4 - p;
            age_sel[k] = a[2:0];
            row_sel[k] = b[2:0];
        end
    end

    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        n_cnt_next   = n_cnt_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (accept && push)
        begin
            if (in_col_inc >= w_eff)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + 13'd1;
            end
            else
            begin
                in_col_next = in_col_inc;
            end
            if (n_cnt_reg != '1)
                n_cnt_next = n_cnt_reg + 13'd1;
            if (emit)
            begin
                if (last)
                begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    n_cnt_next   = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
                else if (out_col_reg + 11'd1 >= w_eff)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + 12'd1;
                end
                else
                begin
                    out_col_next = out_col_reg + 11'd1;
                end
            end
        end
        if (cfg_we && cfg_index <= REG_HEIGHT)
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            n_cnt_next   = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ksel_reg    <= 1'b0;
            width_reg   <= RST_WIDTH;
            height_reg  <= RST_HEIGHT;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            n_cnt_reg   <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            f1_v_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_KERNEL: ksel_reg   <= cfg_data[0];
                    REG_WIDTH:  width_reg  <= cfg_data[IW_W-1:0];
                    REG_HEIGHT: height_reg <= cfg_data[IH_W-1:0];
                    default:    ;
                endcase
            end
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            n_cnt_reg   <= n_cnt_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            f1_v_reg    <= accept && push;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f1_row_lo_reg <= in_row_reg[LINE_W-1:0];
            f1_pix_reg    <= real_px ? s_pixel : '0;
            f1_emit_reg   <= emit;
            f1_last_reg   <= last;
            f1_ksel_reg   <= ksel_reg;
            f1_age_reg    <= age_sel;
            f1_rsel_reg   <= row_sel;
        end
    end

    for (genvar l = 0; l < LINE_COUNT; l++)
    begin : g_line
        mf_ram #(
            .WIDTH (PIX_W),
            .DEPTH (MAX_WIDTH)
        ) u_line (
            .clk   (clk),
            .we    (accept && real_px && (in_row_reg[LINE_W-1:0] == LINE_W'(l))),
            .waddr (AW'(in_col_reg)),
            .wdata (s_pixel),
            .raddr (AW'(in_col_reg)),
            .rdata (ram_rd[l])
        );
    end

    always_comb
    begin
        push_data.emit    = f1_emit_reg;
        push_data.last    = f1_last_reg;
        push_data.ksel    = f1_ksel_reg;
        push_data.age_sel = f1_age_reg;
        push_data.row_sel = f1_rsel_reg;
        for (int j = 0; j < LINE_COUNT; j++)
        begin
            push_data.px[j] = ram_rd[LINE_W'(f1_row_lo_reg + LINE_W'(j))];
        end
        push_data.px[WIN-1] = f1_pix_reg;
    end

    assign push_v = f1_v_reg;

endmodule

>>> src/mf_queue.sv
// Short queue of assembled columns between front and back ends.
// Depends on mf_pkg.
module mf_queue
    import mf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_v,
    input  col_entry_t         push_data,
    input  logic               pop,
    output logic               q_valid,
    output col_entry_t         q_data,
    output logic [Q_LVL_W-1:0] q_level
);

    localparam int PW = $clog2(Q_DEPTH);

    col_entry_t         slot_reg [Q_DEPTH];
    logic [PW-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [Q_LVL_W-1:0] cnt_reg;
    logic               do_pop;

    assign do_pop  = pop && (cnt_reg != '0);
    assign q_valid = cnt_reg != '0;
    assign q_data  = slot_reg[rd_ptr_reg];
    assign q_level = cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push_v)
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            cnt_reg <= cnt_reg + Q_LVL_W'(push_v) - Q_LVL_W'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_v)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

>>> src/mf_back.sv
// Back end: window shift, tap selection, weighted sum and division by
// reciprocal multiplication. Depends on mf_pkg.
module mf_back
    import mf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  col_entry_t       q_data,
    output logic             q_pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [PIX_W-1:0] m_pixel,
    output logic             m_last
);

    win_t                                  win_reg;
    logic                                  b0_v_reg, b1_v_reg, b2_v_reg, b3_v_reg, b4_v_reg;
    logic                                  out_v_reg;
    logic                                  b0_last_reg, b1_last_reg, b2_last_reg;
    logic                                  b3_last_reg, b4_last_reg, out_last_reg;
    logic                                  b0_ksel_reg, b1_ksel_reg, b2_ksel_reg;
    sel_vec_t                              b0_age_reg, b0_rsel_reg;
    logic [WIN-1:0][WIN-1:0][TAP_W-1:0]    tap_reg, tap_next;
    logic [WIN-1:0][RSUM_W-1:0]            rsum_reg, rsum_next;
    logic [SUM_W-1:0]                      sum_reg, sum_next;
    logic [RECIP_W-1:0]                    recip_reg;
    logic [PROD_W-1:0]                     prod_reg;
    logic [PIX_W-1:0]                      out_pix_reg;
    logic                                  adv;

    function automatic logic [PIX_W-1:0] win_at(input win_t w, input logic [2:0] a,
                                                input logic [2:0] r);
        logic [PIX_W-1:0] v;
        v = '0;
        if (a < 3'd5 && r < 3'd5)
            v = w[a][r];
        return v;
    endfunction

    assign adv      = !out_v_reg || m_tready;
    assign q_pop    = q_valid && adv;
    assign m_tvalid = out_v_reg;
    assign m_pixel  = out_pix_reg;
    assign m_last   = out_last_reg;

    always_comb
    begin
        for (int i = 0; i < WIN; i++)
        begin
            for (int j = 0; j < WIN; j++)
            begin
                if (tap_weight(b0_ksel_reg, i, j) == 2'd0)
                    tap_next[i][j] = '0;
                else
                    tap_next[i][j] = TAP_W'(win_at(win_reg, b0_age_reg[j], b0_rsel_reg[i]))
                                   * TAP_W'(tap_weight(b0_ksel_reg, i, j));
            end
        end
        for (int i = 0; i < WIN; i++)
        begin
            rsum_next[i] = '0;
            for (int j = 0; j < WIN; j++)
            begin
                rsum_next[i] = rsum_next[i] + RSUM_W'(tap_reg[i][j]);
            end
        end
        sum_next = '0;
        for (int i = 0; i < WIN; i++)
        begin
            sum_next = sum_next + SUM_W'(rsum_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg   <= '0;
            b0_v_reg  <= 1'b0;
            b1_v_reg  <= 1'b0;
            b2_v_reg  <= 1'b0;
            b3_v_reg  <= 1'b0;
            b4_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            if (q_pop)
            begin
                for (int a = WIN - 1; a > 0; a--)
                begin
                    win_reg[a] <= win_reg[a-1];
                end
                win_reg[0] <= q_data.px;
            end
            b0_v_reg  <= q_pop && q_data.emit;
            b1_v_reg  <= b0_v_reg;
            b2_v_reg  <= b1_v_reg;
            b3_v_reg  <= b2_v_reg;
            b4_v_reg  <= b3_v_reg;
            out_v_reg <= b4_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b0_last_reg  <= q_data.last;
            b0_ksel_reg  <= q_data.ksel;
            b0_age_reg   <= q_data.age_sel;
            b0_rsel_reg  <= q_data.row_sel;
            tap_reg      <= tap_next;
            b1_last_reg  <= b0_last_reg;
            b1_ksel_reg  <= b0_ksel_reg;
            rsum_reg     <= rsum_next;
            b2_last_reg  <= b1_last_reg;
            b2_ksel_reg  <= b1_ksel_reg;
            sum_reg      <= sum_next;
            recip_reg    <= b2_ksel_reg ? RECIP_35 : RECIP_9;
            b3_last_reg  <= b2_last_reg;
            prod_reg     <= PROD_W'(sum_reg) * PROD_W'(recip_reg);
            b4_last_reg  <= b3_last_reg;
            out_pix_reg  <= prod_reg[DIV_SHIFT+PIX_W-1:DIV_SHIFT];
            out_last_reg <= b4_last_reg;
        end
    end

endmodule

>>> src/mean_filter_3x3_5x5_core.sv
// Top level of the streaming 3x3 box / 5x5 weighted mean filter.
// Depends on mf_pkg, mf_front, mf_queue and mf_back.
//
// Takes one pixel or drain transfer per clock while s_tready is high and gives one
// filtered pixel per clock once the pipeline is full and m_tready is high; each
// transfer passes one line-store read, the queue and five arithmetic stages
// between input and output. The first result of a frame follows P*W+P input positions
// later (P = 1 for 3x3, 2 for 5x5, W = image width); drain transfers flush the tail.
// The line store is four single-port-write RAMs of MAX_WIDTH bytes, one per
// stored row, read at one column per clock; it needs no clearing after reset.
// Configuration writes restart the frame and must be made while idle.
module mean_filter_3x3_5x5_core
    import mf_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] pixel_in
    input  logic                 s_tuser,   // [0] drain
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // [7:0] pixel_out
    output logic                 m_tlast    // frame_end
);

    logic               push_v;
    col_entry_t         push_data;
    logic               q_pop;
    logic               q_valid;
    col_entry_t         q_data;
    logic [Q_LVL_W-1:0] q_level;

    mf_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_pixel   (s_tdata),
        .s_drain   (s_tuser),
        .q_level   (q_level),
        .push_v    (push_v),
        .push_data (push_data)
    );

    mf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_v    (push_v),
        .push_data (push_data),
        .pop       (q_pop),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_level   (q_level)
    );

    mf_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_pixel  (m_tdata),
        .m_last   (m_tlast)
    );

endmodule

>>> src/mf_checker.sv
// Port-level checks for the mean filter core, bound to the top level.
// Depends on mean_filter_3x3_5x5_core_assert.svh.
`include "mean_filter_3x3_5x5_core_assert.svh"

module mf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    `MF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output transfer changed while stalled")
    `MF_ASSERT_NOW(a_ready_after_reset, !$past(rst_n), s_tready, "input not ready after reset")
    `MF_ASSERT_NOW(a_idle_after_reset, !$past(rst_n), !m_tvalid, "output valid straight after reset")
    `MF_ASSERT_NEXT(a_no_instant_out, !$past(rst_n) && !s_tvalid, !m_tvalid, "output without any input transfer")

endmodule

bind mean_filter_3x3_5x5_core mf_checker u_mf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

>>> tb/testbench.sv
// Self-checking testbench for mean_filter_3x3_5x5_core: a behavioural smoothing
// model predicts each filtered pixel, which is compared with the master stream.
// Depends on mf_pkg and the core RTL.
module testbench
    import mf_pkg::*;
();

    localparam int MAXW = 1024;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int ITEM_TARGET = 850;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [7:0]           m_tdata;
    logic                 m_tlast;

    typedef struct packed {
        logic [7:0] pix;
        logic       fend;
    } smooth_px_t;

    smooth_px_t pending_px[$];

    // filter state
    logic        f_ksel;
    logic [10:0] f_width;
    logic [12:0] f_height;
    logic [7:0]  rows[4][MAXW];
    logic [7:0]  win_px[5][5];
    int unsigned in_col, in_row, out_col, out_row;

    int  mismatches;
    int  idle_cycles;
    int  sent_items;
    bit  calm;

    mean_filter_3x3_5x5_core i_dut (.*);

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic int unsigned eff_w();
        if (f_width < 2) return 2;
        if (f_width > MAXW) return MAXW;
        return f_width;
    endfunction

    function automatic int unsigned eff_h();
        if (f_height < 2) return 2;
        if (f_height > 4096) return 4096;
        return f_height;
    endfunction

    function automatic int mirror(input int y, input int n);
        if (y < 0) return -y - 1;
        if (y >= n) return 2 * n - 1 - y;
        return y;
    endfunction

    function automatic void reset_position();
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
    endfunction

    function automatic void smooth_step(input logic [7:0] pix, input logic drain);
        int unsigned w, h, lag, n, acc, wt;
        int p, r, c, y, x, age, rr, ar, ac;
        bit in_frame, real_px;
        smooth_px_t res;
        w = eff_w();
        h = eff_h();
        p = f_ksel ? 2 : 1;
        lag = p * w + p;
        in_frame = in_row < h;
        real_px = in_frame && !drain;
        if (in_frame && !real_px) return;
        for (int a = 4; a > 0; a--)
            for (int k = 0; k < 5; k++)
                win_px[a][k] = win_px[a-1][k];
        for (int k = 0; k < 4; k++)
            win_px[0][k] = rows[(in_row + k) % 4][in_col % MAXW];
        win_px[0][4] = real_px ? pix : 8'd0;
        if (real_px) rows[in_row % 4][in_col % MAXW] = pix;
        n = in_row * w + in_col;
        in_col++;
        if (in_col >= w)
        begin
            in_col = 0;
            in_row++;
        end
        if (n < lag) return;
        r = out_row;
        c = out_col;
        acc = 0;
        for (int dr = -p; dr <= p; dr++)
            for (int dc = -p; dc <= p; dc++)
            begin
                y = mirror(r + dr, h);
                x = mirror(c + dc, w);
                age = c + p - x;
                rr = y - r - p + 4;
                wt = 1;
                if (p == 2)
                begin
                    ar = dr < 0 ? -dr : dr;
                    ac = dc < 0 ? -dc : dc;
                    wt = 3 - (ar > ac ? ar : ac);
                end
                if (age >= 0 && age < 5 && rr >= 0 && rr < 5)
                    acc += wt * win_px[age][rr];
            end
        res.pix = 8'(p == 2 ? acc / 35 : acc / 9);
        res.fend = (out_row == h - 1) && (out_col == w - 1);
        pending_px.push_back(res);
        if (res.fend)
            reset_position();
        else
        begin
            out_col++;
            if (out_col >= w)
            begin
                out_col = 0;
                out_row++;
            end
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch: %s got %0d expected %0d", what, got, want);
        mismatches++;
    endtask

    // random idling, with a calm stretch
    function automatic bit take_break();
        return !calm && ($urandom_range(0, 99) < 20);
    endfunction

    task automatic send_transfer(input logic [7:0] pix, input logic drain);
        if (take_break())
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
            while (take_break())
                @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= drain;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        smooth_step(pix, drain);
        sent_items++;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_px.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(val);
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_KERNEL: f_ksel = val[0];
            REG_WIDTH:  f_width = 11'(val);
            REG_HEIGHT: f_height = 13'(val);
            default: ;
        endcase
        if (idx <= REG_HEIGHT) reset_position();
        @(negedge clk);
    endtask

    task automatic set_frame(input bit ksel, input int w, input int h);
        write_reg(REG_KERNEL, ksel);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
    endtask

    // one frame; pixels are drawn from 'style', tail flushed with extra transfers, mostly drains
    task automatic run_frame(input int style, input int noise);
        int unsigned total, lag;
        logic [7:0] v;
        total = eff_w() * eff_h();
        lag = (f_ksel ? 2 : 1) * (eff_w() + 1);
        for (int i = 0; i < total; i++)
        begin
            if (noise > 0 && $urandom_range(0, 99) < noise)
                send_transfer(8'($urandom), 1'b1);
            case (style)
                0: v = 8'hFF;
                1: v = 8'h00;
                2: v = (i % 2) ? 8'hFF : 8'h00;
                default: v = 8'($urandom);
            endcase
            send_transfer(v, 1'b0);
        end
        for (int i = 0; i < lag; i++)
            send_transfer(8'($urandom), $urandom_range(0, 3) != 0);
        wait_idle();
    endtask

    task automatic test_directed();
        set_frame(1'b0, 2, 2);
        run_frame(0, 0);
        run_frame(2, 0);
        set_frame(1'b1, 2, 2);
        run_frame(0, 0);
        run_frame(3, 0);
        set_frame(1'b1, 3, 3);
        run_frame(2, 10);
        // out-of-range sizes clamp to the minimum
        set_frame(1'b0, 0, 1);
        run_frame(3, 0);
        // unused register index leaves the frame alone
        write_reg(REG_UNUSED, 8191);
    endtask

    task automatic test_random();
        while (sent_items < ITEM_TARGET)
        begin
            set_frame($urandom_range(0, 1), $urandom_range(2, 8), $urandom_range(2, 6));
            run_frame(3, 5);
        end
    endtask

    task automatic test_abandon();
        // leave a frame half done, then restart
        set_frame(1'b0, 4, 4);
        for (int i = 0; i < 9; i++)
            send_transfer(8'($urandom), 1'b0);
        wait_idle();
        set_frame(1'b1, 5, 4);
        run_frame(3, 0);
    endtask

    always @(negedge clk)
        m_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 20);

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_px.size() == 0)
                report_mismatch("unexpected pixel", m_tdata, -1);
            else
            begin
                if (m_tdata !== pending_px[0].pix)
                    report_mismatch("pixel_out", m_tdata, pending_px[0].pix);
                if (m_tlast !== pending_px[0].fend)
                    report_mismatch("frame_end", m_tlast, pending_px[0].fend);
                void'(pending_px.pop_front());
            end
        end

    always @(posedge clk)
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("** mean_filter_3x3_5x5_core: FAILED **");
                $finish;
            end
        end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        mismatches = 0;
        idle_cycles = 0;
        sent_items = 0;
        calm = 1'b0;
        f_ksel = 1'b0;
        f_width = 11'd640;
        f_height = 13'd480;
        reset_position();
        for (int a = 0; a < 5; a++)
            for (int k = 0; k < 5; k++)
                win_px[a][k] = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        calm = 1'b1;
        test_directed();
        test_abandon();
        calm = 1'b0;
        test_random();
        wait_idle();
        if (mismatches == 0)
            $display("** mean_filter_3x3_5x5_core: PASSED **");
        else
            $display("** mean_filter_3x3_5x5_core: FAILED **");
        $finish;
    end
endmodule
